@@ design/fcte_pkg.sv @@
// Package for the FAT cluster table engine.
// Holds the transaction structs, operation, status and result codes, and the entry format helpers.
// No dependencies.
package fcte_pkg;

    localparam int FCTE_TABLE_ENTRIES = 4096;
    // highest cluster number the 12-bit count can make valid is 4096
    localparam int FCTE_CLUSTER_SPAN  = 4097;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_ALLOC = 3'd2;
    localparam logic [2:0] OP_FREE  = 3'd3;
    localparam logic [2:0] OP_WALK  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_FREE    = 3'd2;
    localparam logic [2:0] ST_NOSPACE = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;

    localparam logic REG_TABLE_KIND    = 1'b0;
    localparam logic REG_CLUSTER_COUNT = 1'b1;

    localparam logic [1:0]  TABLE_KIND_RST    = 2'd2;
    localparam logic [11:0] CLUSTER_COUNT_RST = 12'd4094;
    localparam logic [12:0] HINT_RST          = 13'd2;

    // result selections from controller to datapath
    localparam logic [2:0] RS_READ     = 3'd0;
    localparam logic [2:0] RS_ZERO_OK  = 3'd1;
    localparam logic [2:0] RS_BAD      = 3'd2;
    localparam logic [2:0] RS_NOSPACE  = 3'd3;
    localparam logic [2:0] RS_ALLOC    = 3'd4;
    localparam logic [2:0] RS_WALK_END = 3'd5;
    localparam logic [2:0] RS_WALK_CLS = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [27:0] cluster;
        logic [27:0] link_value;
        logic        link_is_end;
        logic [11:0] steps;
    } t_in_item;

    typedef struct packed {
        logic [27:0] result_cluster;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       mem_rd_cur;
        logic       link_wr;
        logic       link_free;
        logic       scan_init;
        logic       scan_inc;
        logic       walk_adv;
        logic       hint_found;
        logic       hint_full;
        logic       out_load;
        logic [2:0] res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [2:0] op;
        logic       cl_ok;
        logic       walk_stop;
        logic       scan_stop;
        logic       data_zero;
        logic       data_end;
        logic       out_free;
    } t_dp_sts;

    function automatic logic [27:0] kind_mask(input logic [1:0] kind);
        logic [27:0] m;
        case (kind)
            KIND_FAT12: m = 28'h0000FFF;
            KIND_FAT16: m = 28'h000FFFF;
            default:    m = 28'hFFFFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [27:0] kind_marker(input logic [1:0] kind);
        logic [27:0] m;
        case (kind)
            KIND_FAT12: m = 28'h0000FF8;
            KIND_FAT16: m = 28'h000FFF8;
            default:    m = 28'hFFFFFF8;
        endcase
        return m;
    endfunction

endpackage

@@ design/fcte_ctrl.sv @@
// Controller state machine for the FAT cluster table engine.
// Sequences clearing, operations, scans and walks; drives fcte_dp through fcte_pkg command structs.
module fcte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fcte_pkg::t_dp_sts i_sts,
    output fcte_pkg::t_dp_cmd o_cmd
);
    import fcte_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_ASCAN = 3'd3;
    localparam logic [2:0] S_ADATA = 3'd4;
    localparam logic [2:0] S_WCHK  = 3'd5;
    localparam logic [2:0] S_WDATA = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_READ: begin
                        if (i_sts.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.res_sel  = i_sts.cl_ok ? RS_READ : RS_BAD;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_WRITE: begin
                        if (i_sts.out_free) begin
                            cmd.link_wr  = i_sts.cl_ok;
                            cmd.out_load = 1'b1;
                            cmd.res_sel  = i_sts.cl_ok ? RS_ZERO_OK : RS_BAD;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_FREE: begin
                        if (i_sts.out_free) begin
                            cmd.link_free = i_sts.cl_ok;
                            cmd.out_load  = 1'b1;
                            cmd.res_sel   = i_sts.cl_ok ? RS_ZERO_OK : RS_BAD;
                            n_state       = S_IDLE;
                        end
                    end
                    OP_ALLOC: begin
                        cmd.scan_init = 1'b1;
                        n_state       = S_ASCAN;
                    end
                    OP_WALK: begin
                        n_state = S_WCHK;
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.res_sel  = RS_BAD;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_ASCAN: begin
                if (i_sts.scan_stop) begin
                    if (i_sts.out_free) begin
                        cmd.hint_full = 1'b1;
                        cmd.out_load  = 1'b1;
                        cmd.res_sel   = RS_NOSPACE;
                        n_state       = S_IDLE;
                    end
                end else begin
                    cmd.mem_rd_cur = 1'b1;
                    n_state        = S_ADATA;
                end
            end
            S_ADATA: begin
                if (i_sts.data_zero) begin
                    if (i_sts.out_free) begin
                        cmd.hint_found = 1'b1;
                        cmd.out_load   = 1'b1;
                        cmd.res_sel    = RS_ALLOC;
                        n_state        = S_IDLE;
                    end
                end else begin
                    cmd.scan_inc = 1'b1;
                    n_state      = S_ASCAN;
                end
            end
            S_WCHK: begin
                if (i_sts.walk_stop) begin
                    if (i_sts.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.res_sel  = RS_WALK_CLS;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.mem_rd_cur = 1'b1;
                    n_state        = S_WDATA;
                end
            end
            S_WDATA: begin
                if (i_sts.data_end) begin
                    if (i_sts.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.res_sel  = RS_WALK_END;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.walk_adv = 1'b1;
                    n_state      = S_WCHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_sts.out_free)
        else $error("result loaded into a full output register");

    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !cmd.load)
        else $error("transaction taken during clearing pass");

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

endmodule

@@ design/fcte_dp.sv @@
// Datapath for the FAT cluster table engine: link table memory, cursor, hint and result register.
// Uses fcte_pkg; driven by fcte_ctrl commands.
module fcte_dp #(
    parameter int TABLE_ENTRIES = fcte_pkg::FCTE_TABLE_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fcte_pkg::t_dp_cmd   i_cmd,
    output fcte_pkg::t_dp_sts   o_sts,
    input  fcte_pkg::t_in_item  i_in,
    input  logic [1:0]          i_table_kind,
    input  logic [11:0]         i_cluster_count,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output fcte_pkg::t_out_item o_out
);
    import fcte_pkg::*;

    localparam int MEM_DEPTH = (TABLE_ENTRIES < FCTE_CLUSTER_SPAN) ? TABLE_ENTRIES
                                                                    : FCTE_CLUSTER_SPAN;
    localparam int AW = $clog2(MEM_DEPTH);

    logic [27:0]   r_link_mem [MEM_DEPTH];
    logic [27:0]   r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic [2:0]    r_op;
    logic [27:0]   r_cl;
    logic [27:0]   r_lv;
    logic          r_end;
    logic [27:0]   r_cur;
    logic [11:0]   r_steps;
    logic [12:0]   r_hint;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [27:0]   mask;
    logic [27:0]   marker;
    logic [27:0]   masked;
    logic [12:0]   lim;
    logic [12:0]   start;
    logic          cl_ok;
    logic          cur_ok;
    logic          cur_in_scan;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [27:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    t_out_item     res;

    assign mask   = kind_mask(i_table_kind);
    assign marker = kind_marker(i_table_kind);
    assign masked = r_rdata & mask;
    assign lim    = {1'b0, i_cluster_count} + 13'd2;
    assign start  = ((r_hint > lim) || (r_hint < 13'd2)) ? 13'd2 : r_hint;

    assign cur_in_scan = (r_cur < {15'd0, lim}) && (r_cur < 28'(MEM_DEPTH));
    assign cl_ok  = (r_cl >= 28'd2) && (r_cl < {15'd0, lim}) && (r_cl < 28'(MEM_DEPTH));
    assign cur_ok = (r_cur >= 28'd2) && cur_in_scan;

    assign wr_en   = i_cmd.clr_wr || i_cmd.link_wr || i_cmd.link_free;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_cl[AW-1:0];
    assign wr_data = i_cmd.link_wr ? (r_end ? marker : (r_lv & mask)) : 28'd0;
    assign rd_en   = i_cmd.load || i_cmd.mem_rd_cur;
    assign rd_addr = i_cmd.load ? i_in.cluster[AW-1:0] : r_cur[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_link_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in.op;
            r_cl  <= i_in.cluster;
            r_lv  <= i_in.link_value;
            r_end <= i_in.link_is_end;
        end
        if (i_cmd.load) begin
            r_cur   <= i_in.cluster;
            r_steps <= i_in.steps;
        end else if (i_cmd.scan_init) begin
            r_cur <= {15'd0, start};
        end else if (i_cmd.scan_inc) begin
            r_cur <= r_cur + 28'd1;
        end else if (i_cmd.walk_adv) begin
            r_cur   <= masked;
            r_steps <= r_steps - 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint <= HINT_RST;
        end else if (i_cmd.hint_found) begin
            r_hint <= r_cur[12:0] + 13'd1;
        end else if (i_cmd.hint_full) begin
            r_hint <= lim;
        end else if (i_cmd.link_free && ({15'd0, r_hint} > r_cl)) begin
            r_hint <= r_cl[12:0];
        end
    end

    always_comb begin
        res = '0;
        case (i_cmd.res_sel)
            RS_READ: begin
                res.result_cluster = masked;
                res.status         = (masked >= marker) ? ST_END : ST_OK;
            end
            RS_ZERO_OK: begin
                res.status = ST_OK;
            end
            RS_NOSPACE: begin
                res.status = ST_NOSPACE;
            end
            RS_ALLOC: begin
                res.result_cluster = r_cur;
                res.status         = ST_OK;
            end
            RS_WALK_END: begin
                res.result_cluster = masked;
                res.status         = ST_END;
            end
            RS_WALK_CLS: begin
                if (r_cur == 28'd0) begin
                    res.status = ST_FREE;
                end else begin
                    res.result_cluster = r_cur;
                    res.status         = cur_ok ? ST_OK : ST_BAD;
                end
            end
            default: begin
                res.status = ST_BAD;
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_sts.clr_last  = (r_clr_addr == AW'(MEM_DEPTH - 1));
    assign o_sts.op        = r_op;
    assign o_sts.cl_ok     = cl_ok;
    assign o_sts.walk_stop = (r_steps == 12'd0) || (r_cur == 28'd0) || !cur_ok;
    assign o_sts.scan_stop = !cur_in_scan;
    assign o_sts.data_zero = (masked == 28'd0);
    assign o_sts.data_end  = (masked >= marker);
    assign o_sts.out_free  = out_free;

    a_link_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.link_wr || i_cmd.link_free) |-> cl_ok)
        else $error("table entry changed for a bad cluster");

    a_one_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.link_wr, i_cmd.link_free}))
        else $error("several table writes in one cycle");

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hint >= 13'd2) && (r_hint <= 13'(FCTE_CLUSTER_SPAN)))
        else $error("search hint out of range");

endmodule

@@ design/fat_cluster_table_engine_top.sv @@
// Top level of the FAT cluster table engine: configuration registers and the APB-style port.
// Instantiates fcte_ctrl and fcte_dp; uses fcte_pkg.
//
// Input channel i_in_valid / o_in_stall carries one operation per transaction
// (read, write, allocate, free, walk); output channel o_out_valid / i_out_stall
// returns exactly one result transaction for each, in order.
// For read, write, free and unknown operations the result is loaded into the output
// register in the cycle after the operation is taken, unless a stalled result still holds it.
// Allocate and walk read one table entry after another through the registered read of the
// link table memory; allocate stops on the first free entry or when none is left, walk on
// an end marker or on a cluster (steps used up, free entry or cluster out of range).
// After reset the link table is cleared, one entry per cycle, over all
// min(TABLE_ENTRIES, 4097) entries; o_in_stall stays high until then, while
// configuration writes are taken as usual.
// A stalled result holds in the output register; one further operation is taken
// and runs up to its result, which then waits until the register is free.
// Registers: table_kind at byte address 0, cluster_count at 4.
module fat_cluster_table_engine_top #(
    parameter int TABLE_ENTRIES = fcte_pkg::FCTE_TABLE_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fcte_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fcte_pkg::t_out_item o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fcte_pkg::*;

    logic [1:0]  r_table_kind;
    logic [11:0] r_cluster_count;
    logic        cfg_wr;
    t_dp_cmd     cmd;
    t_dp_sts     sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_kind    <= TABLE_KIND_RST;
            r_cluster_count <= CLUSTER_COUNT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TABLE_KIND) begin
                r_table_kind <= pwdata[1:0];
            end else begin
                r_cluster_count <= pwdata[11:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CLUSTER_COUNT) ? {20'd0, r_cluster_count}
                                                    : {30'd0, r_table_kind};

    fcte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fcte_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in            (i_in),
        .i_table_kind    (r_table_kind),
        .i_cluster_count (r_cluster_count),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out           (o_out)
    );

endmodule

@@ verif/fat_cluster_table_engine_top_tb.sv @@
// Self-checking testbench for fat_cluster_table_engine_top: a directed pass, then random phases
// over several table formats and cluster counts, with results predicted by an in-bench table copy.
// Depends on fcte_pkg and the design sources only.
module fat_cluster_table_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcte_pkg::*;

    localparam int          WATCHDOG_LIMIT = 50000;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          OPS_PER_PHASE  = 225;
    localparam int          RAND_PHASES    = 8;
    localparam logic [2:0]  OP_BAD_LO      = 3'd5;
    localparam logic [2:0]  OP_BAD_HI      = 3'd7;
    localparam logic [1:0]  KIND_FAT32     = 2'd2;
    localparam logic [1:0]  KIND_ALIAS     = 2'd3;
    localparam logic [27:0] CL_MAX         = 28'hFFFFFFF;
    localparam logic [11:0] STEPS_MAX      = 12'hFFF;

    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_queued_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [27:0] fat_mirror [FCTE_TABLE_ENTRIES];
    logic [12:0] next_free_hint;
    logic [1:0]  kind_cfg;
    logic [11:0] count_cfg;

    t_queued_op  pending_ops [$];
    t_out_item   expected_results [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    logic [1:0]  phase_kind  [RAND_PHASES] = '{KIND_FAT12, KIND_FAT16, KIND_ALIAS, KIND_FAT32,
                                               KIND_FAT12, KIND_FAT16, KIND_FAT32, KIND_FAT12};
    logic [11:0] phase_count [RAND_PHASES] = '{12'd30, 12'd4094, 12'd12, 12'd1,
                                               12'd4095, 12'd0, 12'd200, 12'd60};

    fat_cluster_table_engine_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [27:0] fat_width_mask();
        case (kind_cfg)
            KIND_FAT12: return 28'h0000FFF;
            KIND_FAT16: return 28'h000FFFF;
            default:    return 28'hFFFFFFF;
        endcase
    endfunction

    function automatic logic [27:0] fat_eoc_marker();
        case (kind_cfg)
            KIND_FAT12: return 28'h0000FF8;
            KIND_FAT16: return 28'h000FFF8;
            default:    return 28'hFFFFFF8;
        endcase
    endfunction

    function automatic bit cluster_in_range(input logic [27:0] cl);
        int unsigned c;
        c = cl;
        return c >= 2 && c <= int'(count_cfg) + 1 && c < FCTE_TABLE_ENTRIES;
    endfunction

    function automatic logic [27:0] fat_entry(input logic [27:0] cl);
        return fat_mirror[cl[11:0]] & fat_width_mask();
    endfunction

    // apply one operation to the table copy and return the answer it should give
    function automatic t_out_item apply_fat_op(input t_in_item it);
        t_out_item   r;
        int unsigned lim;
        int unsigned c;
        logic [27:0] cur;
        logic [27:0] raw;
        bit          found;
        bit          eoc;
        r = '0;
        r.status = ST_OK;
        case (it.op)
            OP_READ: begin
                if (!cluster_in_range(it.cluster)) begin
                    r.status = ST_BAD;
                end else begin
                    r.result_cluster = fat_entry(it.cluster);
                    r.status = (r.result_cluster >= fat_eoc_marker()) ? ST_END : ST_OK;
                end
            end
            OP_WRITE: begin
                if (!cluster_in_range(it.cluster)) begin
                    r.status = ST_BAD;
                end else begin
                    fat_mirror[it.cluster[11:0]] = it.link_is_end ? fat_eoc_marker()
                                                 : (it.link_value & fat_width_mask());
                end
            end
            OP_ALLOC: begin
                lim = int'(count_cfg) + 2;
                c = next_free_hint;
                found = 1'b0;
                if (c > lim || c < 2) c = 2;
                while (c < lim && c < FCTE_TABLE_ENTRIES) begin
                    if (fat_entry(28'(c)) == '0) begin
                        found = 1'b1;
                        break;
                    end
                    c++;
                end
                if (found) begin
                    next_free_hint = 13'(c + 1);
                    r.result_cluster = 28'(c);
                end else begin
                    next_free_hint = 13'(lim);
                    r.status = ST_NOSPACE;
                end
            end
            OP_FREE: begin
                if (!cluster_in_range(it.cluster)) begin
                    r.status = ST_BAD;
                end else begin
                    if (next_free_hint > it.cluster) next_free_hint = 13'(it.cluster);
                    fat_mirror[it.cluster[11:0]] = '0;
                end
            end
            OP_WALK: begin
                cur = it.cluster;
                raw = '0;
                eoc = 1'b0;
                for (int i = 0; i < int'(it.steps); i++) begin
                    if (cur == '0 || !cluster_in_range(cur)) break;
                    raw = fat_entry(cur);
                    if (raw >= fat_eoc_marker()) begin
                        eoc = 1'b1;
                        break;
                    end
                    cur = raw;
                end
                if (eoc) begin
                    r.status = ST_END;
                    r.result_cluster = raw;
                end else if (cur == '0) begin
                    r.status = ST_FREE;
                end else if (!cluster_in_range(cur)) begin
                    r.status = ST_BAD;
                    r.result_cluster = cur;
                end else begin
                    r.result_cluster = cur;
                end
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    task automatic queue_op(input logic [2:0] op, input logic [27:0] cl, input logic [27:0] lv,
                            input logic is_end, input logic [11:0] steps, input bit drain);
        t_queued_op q;
        q.item.op = op;
        q.item.cluster = cl;
        q.item.link_value = lv;
        q.item.link_is_end = is_end;
        q.item.steps = steps;
        q.drain_first = drain;
        pending_ops.push_back(q);
    endtask

    function automatic logic [27:0] pick_cluster();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 80) return 28'($urandom_range(int'(count_cfg) + 3));
        if (sel < 90) return 28'($urandom());
        return (sel < 95) ? 28'($urandom_range(3)) : 28'($urandom_range(4097, 4094));
    endfunction

    function automatic logic [27:0] pick_link();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70) return 28'($urandom_range(int'(count_cfg) + 2));
        if (sel < 85) return '0;
        return 28'($urandom());
    endfunction

    function automatic logic [11:0] pick_steps();
        return ($urandom_range(99) < 95) ? 12'($urandom_range(12)) : 12'($urandom_range(4095));
    endfunction

    task automatic queue_random_phase(input int n_ops);
        int unsigned hi;
        int unsigned chain_len;
        int unsigned sel;
        int unsigned heads [6];
        logic [27:0] lv;
        logic        is_end;
        logic [2:0]  op;
        int          queued;
        queued = 0;
        hi = (int'(count_cfg) + 1 > FCTE_TABLE_ENTRIES - 1) ? FCTE_TABLE_ENTRIES - 1
                                                            : int'(count_cfg) + 1;
        while (queued < n_ops) begin
            sel = $urandom_range(99);
            if (sel < 30 && count_cfg != '0) begin
                // link a short chain, then walk it from the head
                chain_len = $urandom_range(5, 1);
                for (int k = 0; k < int'(chain_len); k++) heads[k] = $urandom_range(hi, 2);
                for (int k = 0; k < int'(chain_len); k++) begin
                    if (k < int'(chain_len) - 1) begin
                        lv = 28'(heads[k + 1]);
                        is_end = 1'b0;
                    end else begin
                        is_end = ($urandom_range(4) != 0);
                        lv = is_end ? 28'($urandom()) : pick_link();
                    end
                    queue_op(OP_WRITE, 28'(heads[k]), lv, is_end, 12'($urandom()), 1'b0);
                end
                queue_op(OP_WALK, 28'(heads[0]), 28'($urandom()), 1'($urandom()),
                         12'($urandom_range(chain_len + 2)), $urandom_range(149) == 0);
                queued += chain_len + 1;
            end else begin
                sel = $urandom_range(99);
                if (sel < 30)      op = OP_WRITE;
                else if (sel < 45) op = OP_READ;
                else if (sel < 60) op = OP_ALLOC;
                else if (sel < 72) op = OP_FREE;
                else if (sel < 95) op = OP_WALK;
                else               op = 3'($urandom_range(OP_BAD_HI, OP_BAD_LO));
                queue_op(op, pick_cluster(), pick_link(), $urandom_range(4) == 0,
                         pick_steps(), $urandom_range(149) == 0);
                queued++;
            end
        end
    endtask

    task automatic write_register(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TABLE_KIND) kind_cfg = val[1:0];
        else                       count_cfg = val[11:0];
    endtask

    task automatic set_table_format(input logic [1:0] kind, input logic [11:0] count);
        write_register(REG_TABLE_KIND, {30'd0, kind});
        write_register(REG_CLUSTER_COUNT, {20'd0, count});
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    // driver: offer the next queued operation, predict on each accepted transaction
    always @(posedge i_clk) begin
        bit         took;
        t_queued_op nxt;
        took = 1'b0;
        if (i_in_valid && !o_in_stall) begin
            expected_results.push_back(apply_fat_op(i_in));
            took = 1'b1;
        end
        if (!i_in_valid || took) begin
            if (i_rst_n && pending_ops.size() != 0
                && !(pending_ops[0].drain_first && expected_results.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_ops.pop_front();
                i_in       <= nxt.item;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: result_cluster %h status %0d",
                       o_out.result_cluster, o_out.status);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out.result_cluster !== exp_r.result_cluster) begin
                    $error("result_cluster: expected %h, actual %h",
                           exp_r.result_cluster, o_out.result_cluster);
                    mismatch_count++;
                end
                if (o_out.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_out.status);
                    mismatch_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles <= 0;
        else                                                              quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        foreach (fat_mirror[i]) fat_mirror[i] = '0;
        next_free_hint = HINT_RST;
        kind_cfg       = TABLE_KIND_RST;
        count_cfg      = CLUSTER_COUNT_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 46;
        set_table_format(KIND_FAT16, 12'd6);
        queue_op(OP_READ,  28'd2,  '0,     1'b0, '0,        1'b0);
        queue_op(OP_READ,  CL_MAX, CL_MAX, 1'b1, STEPS_MAX, 1'b0);
        queue_op(OP_WRITE, 28'd2,  28'd3,  1'b0, '0,        1'b0);
        queue_op(OP_WRITE, 28'd3,  28'd4,  1'b0, '0,        1'b0);
        queue_op(OP_WRITE, 28'd4,  CL_MAX, 1'b1, '0,        1'b0);
        queue_op(OP_WRITE, 28'd5,  CL_MAX, 1'b0, '0,        1'b0);
        queue_op(OP_READ,  28'd4,  '0,     1'b0, '0,        1'b0);
        queue_op(OP_WALK,  28'd2,  '0,     1'b0, STEPS_MAX, 1'b1);
        queue_op(OP_WALK,  28'd2,  '0,     1'b0, '0,        1'b0);
        queue_op(OP_WALK,  28'd0,  '0,     1'b0, 12'd5,     1'b0);
        queue_op(OP_WALK,  28'd8,  '0,     1'b0, '0,        1'b0);
        queue_op(OP_WRITE, 28'd6,  28'd8,  1'b0, '0,        1'b0);
        queue_op(OP_WALK,  28'd6,  '0,     1'b0, 12'd3,     1'b0);
        queue_op(OP_WRITE, 28'd7,  28'd7,  1'b0, '0,        1'b0);
        queue_op(OP_WALK,  28'd7,  '0,     1'b0, STEPS_MAX, 1'b0);
        queue_op(OP_ALLOC, '0,     '0,     1'b0, '0,        1'b0);
        queue_op(OP_FREE,  28'd3,  '0,     1'b0, '0,        1'b0);
        queue_op(OP_ALLOC, '0,     '0,     1'b0, '0,        1'b0);
        queue_op(OP_ALLOC, '0,     '0,     1'b0, '0,        1'b0);
        queue_op(OP_WRITE, 28'd1,  28'd2,  1'b0, '0,        1'b0);
        queue_op(OP_FREE,  28'd0,  '0,     1'b0, '0,        1'b0);
        queue_op(OP_BAD_LO, 28'd2, '0,     1'b0, '0,        1'b0);
        queue_op(OP_BAD_HI, CL_MAX, CL_MAX, 1'b1, STEPS_MAX, 1'b0);
        queue_op(OP_WRITE, 28'd2,  '0,     1'b0, '0,        1'b0);
        queue_op(OP_WALK,  28'd2,  '0,     1'b0, 12'd1,     1'b0);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct = 24;
                recv_idle_pct = 46;
            end else if (p < 5) begin
                send_idle_pct = 46;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_table_format(phase_kind[p], phase_count[p]);
            queue_random_phase(OPS_PER_PHASE);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/fcte_pkg.sv
design/fcte_ctrl.sv
design/fcte_dp.sv
design/fat_cluster_table_engine_top.sv
verif/fat_cluster_table_engine_top_tb.sv
